// ===== rtl/l2_distance_matrix_macros.svh =====
// Assertion helpers used by the top-level RTL. Both expect clk and rst_n in scope.
`ifndef L2_DISTANCE_MATRIX_MACROS_SVH
`define L2_DISTANCE_MATRIX_MACROS_SVH

// same-cycle implication
`define L2DM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define L2DM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/l2dm_pkg.sv =====
package l2dm_pkg;

  localparam int MAX_DIM_DEF    = 256;
  localparam int DB_VECTORS_DEF = 64;

  localparam int REQ_W  = 1;
  localparam int VEC_W  = 6;
  localparam int ELEM_W = 8;
  localparam int VAL_W  = 16;
  localparam int DIST_W = 40;
  localparam int DIM_W  = 9;
  localparam int DBN_W  = 7;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [REQ_W-1:0] REQ_LOAD  = 1'b0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM = 1'b0,
    REG_DB  = 1'b1
  } cfg_reg_t;

  // query element travelling down the cell row
  typedef struct packed {
    logic                    valid;
    logic                    clear;
    logic [ELEM_W-1:0]       elem;
    logic signed [VAL_W-1:0] value;
  } tok_t;

  // database write, broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [VEC_W-1:0]  vec;
    logic [ELEM_W-1:0] elem;
    logic [VAL_W-1:0]  value;
  } wr_t;

  // result unload control
  typedef struct packed {
    logic cap;
    logic shift;
  } ctl_t;

endpackage

// ===== rtl/l2dm_cell.sv =====
module l2dm_cell #(
  parameter int MAX_DIM = l2dm_pkg::MAX_DIM_DEF,
  parameter int CELL_ID = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  l2dm_pkg::tok_t              tok_i,
  output l2dm_pkg::tok_t              tok_o,
  input  l2dm_pkg::wr_t               wr_i,
  input  l2dm_pkg::ctl_t              ctl_i,
  input  logic [l2dm_pkg::DBN_W-1:0]  db_eff_i,
  input  logic [l2dm_pkg::DIST_W-1:0] sh_i,
  output logic [l2dm_pkg::DIST_W-1:0] sh_o
);
  import l2dm_pkg::*;

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int IW = (AW > ELEM_W) ? AW : ELEM_W;

  logic [VAL_W-1:0]  mem [MAX_DIM];
  logic [VAL_W-1:0]  rd_r;
  tok_t              tok1_r;
  logic              v2_r;
  logic              clr2_r;
  logic [31:0]       sq_r;
  logic [DIST_W-1:0] acc_r;
  logic [DIST_W-1:0] sh_r;

  logic [IW-1:0]     wr_x;
  logic [IW-1:0]     rd_x;
  logic [AW-1:0]     wr_a;
  logic [AW-1:0]     rd_a;
  logic [VAL_W:0]    diff;
  logic [VAL_W:0]    mag;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] sat;
  logic              en;

  assign wr_x = IW'(wr_i.elem);
  assign rd_x = IW'(tok_i.elem);
  assign wr_a = wr_x[AW-1:0];
  assign rd_a = rd_x[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_i.en && (wr_i.vec == VEC_W'(CELL_ID))) begin
      mem[wr_a] <= wr_i.value;
    end
    rd_r <= mem[rd_a];
  end

  assign diff = {tok1_r.value[VAL_W-1], tok1_r.value} - {rd_r[VAL_W-1], rd_r};
  assign mag  = diff[VAL_W] ? (~diff + 1'b1) : diff;
  assign sum  = {1'b0, acc_r} + (DIST_W+1)'(sq_r);
  assign sat  = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  assign en   = DBN_W'(CELL_ID) < db_eff_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r <= '0;
      v2_r   <= 1'b0;
    end else begin
      tok1_r <= tok_i;
      v2_r   <= tok1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    clr2_r <= tok1_r.clear;
    sq_r   <= mag[VAL_W-1:0] * mag[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      if (en) begin
        acc_r <= clr2_r ? DIST_W'(sq_r) : sat;
      end else if (clr2_r) begin
        acc_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.cap) begin
      sh_r <= acc_r;
    end else if (ctl_i.shift) begin
      sh_r <= sh_i;
    end
  end

  assign tok_o = tok1_r;
  assign sh_o  = sh_r;

endmodule

// ===== rtl/l2_distance_matrix.sv =====
// Channel  Dir  Handshake            Contents
// in_      in   in_tvalid/in_tready  tuser: req_type; tdata: vec_index, elem_index, value
// out_     out  out_tvalid/out_tready tdata: db_index, distance; tlast: last_of_run
// cfg_     in   cfg_we               cfg_index, cfg_wdata
//
// Load word: written into the addressed cell; the block stays idle. Query
// element: walks down the row of DB_VECTORS cells and through the multiply and add
// stages, no new word taken meanwhile. Final element of a query then unloads the row, one word per vector in use.
// Reset: synchronous, active low; database and sums stay as they were.
// out_tready low holds the unload; the row then waits in place.
module l2_distance_matrix #(
  parameter int MAX_DIM    = l2dm_pkg::MAX_DIM_DEF,
  parameter int DB_VECTORS = l2dm_pkg::DB_VECTORS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [l2dm_pkg::IN_TDATA_W-1:0]  in_tdata,   // vec_index, elem_index, value
  input  logic [l2dm_pkg::REQ_W-1:0]       in_tuser,   // req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [l2dm_pkg::OUT_TDATA_W-1:0] out_tdata,  // db_index, distance
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [l2dm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [l2dm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import l2dm_pkg::*;

  `include "l2_distance_matrix_macros.svh"

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = (DW > DIM_W) ? DW : DIM_W;

  localparam int VEC_LO  = 0;
  localparam int ELEM_LO = VEC_LO + VEC_W;
  localparam int VAL_LO  = ELEM_LO + ELEM_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [DIM_W-1:0]   dim_r;
  logic [DBN_W-1:0]   db_r;
  tok_t               tok_r, tok_nxt;
  logic               last_r, last_nxt;
  logic [1:0]         done_d_r;
  logic [VEC_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  logic [VEC_W-1:0]   in_vec;
  logic [ELEM_W-1:0]  in_elem;
  logic [VAL_W-1:0]   in_val;
  logic [CW-1:0]      dim_x;
  logic [CW-1:0]      dim_eff;
  logic [CW-1:0]      elem_x;
  logic [DBN_W-1:0]   db_eff;
  logic               accept;
  logic               in_range;
  logic               is_last;
  logic               cnt_last;
  logic               load_out;
  logic               last_taken;
  wr_t                wr;
  ctl_t               ctl;

  tok_t               tok [DB_VECTORS+1];
  logic [DIST_W-1:0]  sh  [DB_VECTORS+1];

  assign in_vec  = in_tdata[VEC_LO +: VEC_W];
  assign in_elem = in_tdata[ELEM_LO +: ELEM_W];
  assign in_val  = in_tdata[VAL_LO +: VAL_W];

  assign dim_x   = CW'(dim_r);
  assign dim_eff = (dim_x == '0) ? CW'(1) :
                   ((dim_x > CW'(MAX_DIM)) ? CW'(MAX_DIM) : dim_x);
  assign db_eff  = (db_r == '0) ? DBN_W'(1) :
                   ((db_r > DBN_W'(DB_VECTORS)) ? DBN_W'(DB_VECTORS) : db_r);
  assign elem_x  = CW'(in_elem);

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_range  = elem_x < dim_eff;
  assign is_last   = elem_x == (dim_eff - CW'(1));

  always_comb begin
    wr.en    = accept && (in_tuser == REQ_LOAD) && (elem_x < CW'(MAX_DIM));
    wr.vec   = in_vec;
    wr.elem  = in_elem;
    wr.value = in_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_W'(256);
      db_r  <= DBN_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DIM: dim_r <= cfg_wdata[DIM_W-1:0];
        REG_DB:  db_r  <= cfg_wdata[DBN_W-1:0];
      endcase
    end
  end

  assign tok[0]          = tok_r;
  assign sh[DB_VECTORS]  = '0;

  for (genvar g = 0; g < DB_VECTORS; g++) begin : g_cell
    l2dm_cell #(
      .MAX_DIM (MAX_DIM),
      .CELL_ID (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .wr_i     (wr),
      .ctl_i    (ctl),
      .db_eff_i (db_eff),
      .sh_i     (sh[g+1]),
      .sh_o     (sh[g])
    );
  end

  assign cnt_last = DBN_W'(cnt_r) == (db_eff - DBN_W'(1));
  assign load_out = (state_r == ST_DRAIN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    tok_nxt       = '0;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    ctl           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_tuser == REQ_QUERY) && in_range) begin
          tok_nxt.valid = 1'b1;
          tok_nxt.clear = (in_elem == '0);
          tok_nxt.elem  = in_elem;
          tok_nxt.value = in_val;
          last_nxt      = is_last;
          state_nxt     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done_d_r[1]) begin
          if (last_r) begin
            ctl.cap   = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_DRAIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DRAIN: begin
        if (load_out) begin
          ctl.shift     = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({sh[0], cnt_r});
          out_last_nxt  = cnt_last;
          cnt_nxt       = cnt_r + VEC_W'(1);
          if (cnt_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tok_r       <= '0;
      last_r      <= 1'b0;
      done_d_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok_r       <= tok_nxt;
      last_r      <= last_nxt;
      done_d_r    <= {done_d_r[0], tok[DB_VECTORS].valid};
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // last word taken with no unload under way
  assign last_taken = out_valid_r && out_tready && out_last_r && in_tready;

  `L2DM_ASSERT_IMP(a_done_in_run, done_d_r[1], state_r == ST_RUN, "done outside run")
  `L2DM_ASSERT_IMP(a_cnt_range, state_r == ST_DRAIN, DBN_W'(cnt_r) < db_eff, "count overrun")
  `L2DM_ASSERT_NXT(a_last_ends_drain, load_out && cnt_last, state_r == ST_IDLE, "drain ran on")
  `L2DM_ASSERT_NXT(a_quiet_after_last, last_taken, !out_tvalid, "word after last")

endmodule
